>>> src/xrd_pkg.sv
package xrd_pkg;

    localparam int unsigned WORD_W = 64;
    localparam int unsigned CNT_W  = 6;

    localparam int unsigned ROT_A   = 55;
    localparam int unsigned SHIFT_A = 14;
    localparam int unsigned ROT_B   = 36;

    localparam logic [WORD_W-1:0] SEED_A_RST = 64'd1;
    localparam logic [WORD_W-1:0] SEED_B_RST = 64'd0;

    localparam logic CMD_DRAW   = 1'b0;
    localparam logic CMD_RESEED = 1'b1;

    localparam logic REG_SEED_A = 1'b0;
    localparam logic REG_SEED_B = 1'b1;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_W - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load_seed;
        logic start;
        logic step;
        logic load_out;
    } xrd_cmd_t;

    typedef struct packed {
        logic span_zero;
        logic step_last;
    } xrd_sts_t;

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v,
                                               input int unsigned n);
        rotl = (v << n) | (v >> (WORD_W - n));
    endfunction

endpackage

>>> src/xrd_ctrl.sv
module xrd_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    input  logic            s_axis_tuser,
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    input  xrd_pkg::xrd_sts_t sts,
    output xrd_pkg::xrd_cmd_t cmd
);
    import xrd_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        s_axis_tready  = 1'b0;
        out_valid_next = out_valid_reg && !m_axis_tready;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    if (s_axis_tuser == CMD_RESEED)
                    begin
                        cmd.load_seed = 1'b1;
                    end
                    else
                    begin
                        cmd.start  = 1'b1;
                        state_next = sts.span_zero ? ST_FINISH : ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                cmd.step = 1'b1;
                if (sts.step_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;

endmodule

>>> src/xrd_dpath.sv
module xrd_dpath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [xrd_pkg::WORD_W-1:0]  cfg_data,
    input  logic [2*xrd_pkg::WORD_W-1:0] s_axis_tdata,
    output logic [2*xrd_pkg::WORD_W-1:0] m_axis_tdata,
    output logic                        m_axis_tuser,
    input  xrd_pkg::xrd_cmd_t           cmd,
    output xrd_pkg::xrd_sts_t           sts
);
    import xrd_pkg::*;

    logic [WORD_W-1:0] seed_a_reg, seed_a_next;
    logic [WORD_W-1:0] seed_b_reg, seed_b_next;
    logic [WORD_W-1:0] gen_a_reg, gen_a_next;
    logic [WORD_W-1:0] gen_b_reg, gen_b_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    logic [WORD_W-1:0] lo_reg, lo_next;
    logic [WORD_W-1:0] span_reg, span_next;
    logic [WORD_W-1:0] raw_reg, raw_next;
    logic [WORD_W-1:0] dvd_reg, dvd_next;
    logic [WORD_W-1:0] rem_reg, rem_next;
    logic              zero_reg, zero_next;
    logic [WORD_W-1:0] ranged_out_reg, ranged_out_next;
    logic [WORD_W-1:0] raw_out_reg, raw_out_next;
    logic              zero_out_reg, zero_out_next;

    logic [WORD_W-1:0] in_lo;
    logic [WORD_W-1:0] in_hi;
    logic [WORD_W-1:0] in_span;
    logic [WORD_W-1:0] mix;
    logic [WORD_W:0]   rem_sh;
    logic [WORD_W:0]   rem_diff;

    assign in_lo   = s_axis_tdata[WORD_W-1:0];
    assign in_hi   = s_axis_tdata[2*WORD_W-1:WORD_W];
    assign in_span = in_hi - in_lo;
    assign mix     = gen_a_reg ^ gen_b_reg;
    assign rem_sh   = {rem_reg, dvd_reg[WORD_W-1]};
    assign rem_diff = rem_sh - {1'b0, span_reg};

    assign sts.span_zero = (in_span == '0);
    assign sts.step_last = (cnt_reg == CNT_LAST);

    always_comb
    begin
        seed_a_next     = seed_a_reg;
        seed_b_next     = seed_b_reg;
        gen_a_next      = gen_a_reg;
        gen_b_next      = gen_b_reg;
        cnt_next        = cnt_reg;
        lo_next         = lo_reg;
        span_next       = span_reg;
        raw_next        = raw_reg;
        dvd_next        = dvd_reg;
        rem_next        = rem_reg;
        zero_next       = zero_reg;
        ranged_out_next = ranged_out_reg;
        raw_out_next    = raw_out_reg;
        zero_out_next   = zero_out_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SEED_A: seed_a_next = cfg_data;
                REG_SEED_B: seed_b_next = cfg_data;
                default:    seed_a_next = seed_a_reg;
            endcase
        end

        if (cmd.load_seed)
        begin
            gen_a_next = seed_a_reg;
            gen_b_next = seed_b_reg;
        end

        if (cmd.start)
        begin
            raw_next   = gen_a_reg + gen_b_reg;
            dvd_next   = gen_a_reg + gen_b_reg;
            gen_a_next = rotl(gen_a_reg, ROT_A) ^ mix ^ (mix << SHIFT_A);
            gen_b_next = rotl(mix, ROT_B);
            lo_next    = in_lo;
            span_next  = in_span;
            zero_next  = (in_span == '0);
            rem_next   = '0;
            cnt_next   = '0;
        end

        // restoring division, one quotient bit per cycle; only the remainder is kept
        if (cmd.step)
        begin
            if (!rem_diff[WORD_W])
            begin
                rem_next = rem_diff[WORD_W-1:0];
            end
            else
            begin
                rem_next = rem_sh[WORD_W-1:0];
            end
            dvd_next = {dvd_reg[WORD_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
        end

        if (cmd.load_out)
        begin
            ranged_out_next = rem_reg + lo_reg;
            raw_out_next    = raw_reg;
            zero_out_next   = zero_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_a_reg <= SEED_A_RST;
            seed_b_reg <= SEED_B_RST;
            gen_a_reg  <= SEED_A_RST;
            gen_b_reg  <= SEED_B_RST;
            cnt_reg    <= '0;
        end
        else
        begin
            seed_a_reg <= seed_a_next;
            seed_b_reg <= seed_b_next;
            gen_a_reg  <= gen_a_next;
            gen_b_reg  <= gen_b_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg         <= lo_next;
        span_reg       <= span_next;
        raw_reg        <= raw_next;
        dvd_reg        <= dvd_next;
        rem_reg        <= rem_next;
        zero_reg       <= zero_next;
        ranged_out_reg <= ranged_out_next;
        raw_out_reg    <= raw_out_next;
        zero_out_reg   <= zero_out_next;
    end

    assign m_axis_tdata = {raw_out_reg, ranged_out_reg};
    assign m_axis_tuser = zero_out_reg;

endmodule

>>> src/xoroshiro128plus_range_draw.sv
// xoroshiro128+ generator answering range draws.
// Input stream (s_axis): one word per command. tuser selects draw (0) or
// reseed (1); tdata carries lower_bound [63:0] and upper_bound [127:64].
// Output stream (m_axis): one word per draw, none per reseed. tdata carries
// ranged_value [63:0] and raw_value [127:64]; tuser is zero_span.
// Config port: cfg_we/cfg_index/cfg_data write seed_word_a (index 0) or
// seed_word_b (index 1); write only while idle. Seeds take effect on reseed.
// A reseed loads the generator from the seeds when it is accepted. A draw
// with a non-zero span goes from acceptance through the bit-serial
// restoring divider, which forms raw mod span, to the result register;
// a zero-span draw skips the divider. One word is worked on at a time; the
// next input word is taken once the previous result has moved into the
// output register, and back-to-back reseeds are taken every cycle.
// Reset loads seeds 1 and 0 and the generator state from them; the output
// register is empty. If the receiver stalls, the finished result waits in
// the output register, the next draw runs, then waits until it is free.
module xoroshiro128plus_range_draw (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [xrd_pkg::WORD_W-1:0]   cfg_data,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [2*xrd_pkg::WORD_W-1:0] s_axis_tdata,  // lower_bound, upper_bound
    input  logic                         s_axis_tuser,  // command
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [2*xrd_pkg::WORD_W-1:0] m_axis_tdata,  // ranged_value, raw_value
    output logic                         m_axis_tuser   // zero_span
);
    import xrd_pkg::*;

    xrd_cmd_t cmd;
    xrd_sts_t sts;

    xrd_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .sts           (sts),
        .cmd           (cmd)
    );

    xrd_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .cmd          (cmd),
        .sts          (sts)
    );

endmodule
